### rtl/cpi_pkg.sv
package cpi_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_MEET = 2'd1,
    ST_SAME_X  = 2'd2
  } status_t;

  // Pipeline control for the multiplier and divider blocks: advance strobe and incoming valid
  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

endpackage

### rtl/cpi_mul.sv
module cpi_mul
  import cpi_pkg::*;
#(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pipe_ctl_t         ctl,
  input  logic [WA-1:0]     a,
  input  logic [WB-1:0]     b,
  output logic [WA+WB-1:0]  p,
  output logic              p_vld
);

  localparam int HA = (WA + 1) / 2;
  localparam int HB = (WB + 1) / 2;
  localparam int WP = WA + WB;

  logic [HA-1:0]            a_lo;
  logic [WA-HA-1:0]         a_hi;
  logic [HB-1:0]            b_lo;
  logic [WB-HB-1:0]         b_hi;
  logic [HA+HB-1:0]         ll_r;
  logic [HA+WB-HB-1:0]      lh_r;
  logic [WA-HA+HB-1:0]      hl_r;
  logic [WA-HA+WB-HB-1:0]   hh_r;
  logic [WP-1:0]            p_r, p_nxt;
  logic [1:0]               vld_r;

  assign a_lo = a[HA-1:0];
  assign a_hi = a[WA-1:HA];
  assign b_lo = b[HB-1:0];
  assign b_hi = b[WB-1:HB];

  // Recombine the four partial products
  always_comb begin
    p_nxt = WP'(ll_r) + (WP'(lh_r) << HB) + (WP'(hl_r) << HA) + (WP'(hh_r) << (HA + HB));
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ll_r <= a_lo * b_lo;
      lh_r <= a_lo * b_hi;
      hl_r <= a_hi * b_lo;
      hh_r <= a_hi * b_hi;
      p_r  <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= {vld_r[0], ctl.vld};
    end
  end

  assign p     = p_r;
  assign p_vld = vld_r[1];

endmodule

### rtl/cpi_div.sv
module cpi_div
  import cpi_pkg::*;
#(
  parameter int NW  = 77,
  parameter int DNW = 51,
  parameter int QB  = 23
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pipe_ctl_t            ctl,
  input  logic signed [NW-1:0] num,
  input  logic [DNW-1:0]       den,
  output logic signed [QB:0]   quo,
  output logic                 quo_vld
);

  logic [NW-1:0]  rem_r [0:QB-1];
  logic [DNW-1:0] den_r [0:QB-1];
  logic [QB-1:0]  q_r   [0:QB];
  logic           neg_r [0:QB];
  logic [QB:0]    vld_r;

  // Take the magnitude, keep the sign
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rem_r[0] <= num[NW-1] ? -num : num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      neg_r[0] <= num[NW-1];
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [NW-1:0] sh;
    logic [NW:0]   diff;
    logic          ge;
    logic [QB-1:0] qn;

    always_comb begin
      sh   = NW'(den_r[k-1]) << (QB - k);
      diff = {1'b0, rem_r[k-1]} - {1'b0, sh};
      ge   = !diff[NW];
      qn   = q_r[k-1];
      qn[QB-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        q_r[k]   <= qn;
        neg_r[k] <= neg_r[k-1];
      end
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          rem_r[k] <= ge ? diff[NW-1:0] : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= {vld_r[QB-1:0], ctl.vld};
    end
  end

  assign quo     = neg_r[QB] ? -$signed({1'b0, q_r[QB]}) : $signed({1'b0, q_r[QB]});
  assign quo_vld = vld_r[QB];

endmodule

### rtl/circle_pair_intersection_top.sv
// Circle pair intersection: two tower positions plus the measured range to
// each go in, the two points where the range circles meet come out.
//
// Input channel in_*: one transfer per tower pair. Output channel out_*:
// one transfer per input, in order. out_tuser carries the status: ok,
// circles do not meet, or towers share x; in the last two cases all four
// point fields are zero. Coordinates are raw fixed-point integers; the
// fraction width only scales them and is invisible to the logic.
//
// Throughput: one tower pair per cycle unless the receiver stalls. Most of
// the pipeline depth lies in the square root (one root bit per stage) and
// the four dividers (one quotient bit per stage) that follow it.
//
// The pipeline moves as one: every stage advances when the output register
// is empty or its transfer completes. When the receiver stalls with a result
// waiting, all stages hold and in_tready drops; nothing is lost or repeated.
// Reset clears only the valid bits; data registers are left as they are.
module circle_pair_intersection_top
  import cpi_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // tower1_x, tower1_y, tower1_range, tower2_x, tower2_y, tower2_range
  input  logic [((6*COORD_BITS-2+7)/8)*8-1:0]           in_tdata,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // first_x, first_y, second_x, second_y
  output logic [((4*(COORD_BITS+2)+7)/8)*8-1:0]         out_tdata,
  // status
  output logic [1:0]                                    out_tuser,
  output logic                                          out_tvalid,
  input  logic                                          out_tready
);

  localparam int N      = COORD_BITS;
  localparam int IN_DW  = ((6*N-2+7)/8)*8;
  localparam int OUT_DW = ((4*(N+2)+7)/8)*8;
  localparam int RB     = N - 1;        // range width
  localparam int DW     = N + 1;        // dx, dy
  localparam int SQW    = 2*N + 1;      // dx^2
  localparam int RSW    = 2*N - 2;      // range^2
  localparam int D2W    = 2*N + 2;      // dx^2 + dy^2
  localparam int KW     = 2*N + 3;      // K, signed
  localparam int KMW    = 2*N + 2;      // |K|
  localparam int DSW    = 4*N + 5;      // discriminant, signed
  localparam int SB     = 2*N + 1;      // root bits
  localparam int DQ     = 2*SB;         // root input bits
  localparam int NW     = 3*N + 5;      // numerators, signed
  localparam int DNW    = D2W + 1;      // 2*d2
  localparam int QB     = N - 1;        // quotient magnitude bits
  localparam int OW     = N + 2;
  localparam int LAT    = 12 + SB + QB;

  localparam int O_X1 = 0;
  localparam int O_Y1 = N;
  localparam int O_R1 = 2*N;
  localparam int O_X2 = 3*N - 1;
  localparam int O_Y2 = 4*N - 1;
  localparam int O_R2 = 5*N - 1;

  typedef struct packed {
    logic                dxneg;
    logic                dyneg;
    logic                dxz;
    logic [N:0]          dxmag;
    logic [N:0]          dymag;
    logic signed [N-1:0] x1;
    logic signed [N-1:0] y1;
  } geo_t;

  typedef struct packed {
    logic           kneg;
    logic [D2W-1:0] d2;
    geo_t           geo;
  } md_t;

  typedef struct packed {
    logic signed [NW-1:0] kdy;
    logic signed [NW-1:0] kdx;
    logic [D2W-1:0]       d2;
    logic                 xsneg;
    logic [N:0]           dxmag;
    logic [N:0]           dymag;
    logic signed [N-1:0]  x1;
    logic signed [N-1:0]  y1;
    status_t              stat;
  } sq_t;

  typedef struct packed {
    logic signed [N-1:0] x1;
    logic signed [N-1:0] y1;
    status_t             stat;
  } ht_t;

  logic       adv;
  pipe_ctl_t  ctl_d, ctl_sq;
  logic [LAT-1:0] vld_r;

  // Field unpack
  logic signed [N-1:0] in_x1, in_y1, in_x2, in_y2;
  logic [RB-1:0]       in_r1, in_r2;

  assign in_x1 = in_tdata[O_X1 +: N];
  assign in_y1 = in_tdata[O_Y1 +: N];
  assign in_r1 = in_tdata[O_R1 +: RB];
  assign in_x2 = in_tdata[O_X2 +: N];
  assign in_y2 = in_tdata[O_Y2 +: N];
  assign in_r2 = in_tdata[O_R2 +: RB];

  // Whole pipeline advances together; the output register is the last stage
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage A
  logic signed [DW-1:0] a_dx_r, a_dy_r;
  logic [RB-1:0]        a_r1_r, a_r2_r;
  logic signed [N-1:0]  a_x1_r, a_y1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx_r <= DW'(in_x2) - DW'(in_x1);
      a_dy_r <= DW'(in_y2) - DW'(in_y1);
      a_r1_r <= in_r1;
      a_r2_r <= in_r2;
      a_x1_r <= in_x1;
      a_y1_r <= in_y1;
    end
  end

  // ---------------------------------------------------------------- stage B
  // Squares of tower offsets and ranges; all narrow enough for one multiplier
  logic signed [2*DW-1:0] dx2_full, dy2_full;
  logic [SQW-1:0]         b_dx2_r, b_dy2_r;
  logic [RSW-1:0]         b_r1s_r, b_r2s_r;
  logic signed [DW-1:0]   dx_abs, dy_abs;
  geo_t                   b_geo_r;

  always_comb begin
    dx2_full = a_dx_r * a_dx_r;
    dy2_full = a_dy_r * a_dy_r;
    dx_abs   = a_dx_r[DW-1] ? -a_dx_r : a_dx_r;
    dy_abs   = a_dy_r[DW-1] ? -a_dy_r : a_dy_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_dx2_r       <= dx2_full[SQW-1:0];
      b_dy2_r       <= dy2_full[SQW-1:0];
      b_r1s_r       <= a_r1_r * a_r1_r;
      b_r2s_r       <= a_r2_r * a_r2_r;
      b_geo_r.dxneg <= a_dx_r[DW-1];
      b_geo_r.dyneg <= a_dy_r[DW-1];
      b_geo_r.dxz   <= (a_dx_r == '0);
      b_geo_r.dxmag <= dx_abs;
      b_geo_r.dymag <= dy_abs;
      b_geo_r.x1    <= a_x1_r;
      b_geo_r.y1    <= a_y1_r;
    end
  end

  // ---------------------------------------------------------------- stage C
  logic [D2W-1:0]       c_d2_r;
  logic signed [KW-1:0] c_rdiff_r;
  logic [RSW-1:0]       c_r1s_r;
  geo_t                 c_geo_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_d2_r    <= D2W'(b_dx2_r) + D2W'(b_dy2_r);
      c_rdiff_r <= $signed(KW'(b_r1s_r)) - $signed(KW'(b_r2s_r));
      c_r1s_r   <= b_r1s_r;
      c_geo_r   <= b_geo_r;
    end
  end

  // ---------------------------------------------------------------- stage D
  // K = r1^2 - r2^2 + d2, held as sign and magnitude for the multipliers
  logic signed [KW-1:0] k_val, k_abs;
  logic [KMW-1:0]       d_kmag_r;
  logic                 d_kneg_r;
  logic [D2W-1:0]       d_d2_r;
  logic [RSW-1:0]       d_r1s_r;
  geo_t                 d_geo_r;

  always_comb begin
    k_val = c_rdiff_r + $signed(KW'(c_d2_r));
    k_abs = k_val[KW-1] ? -k_val : k_val;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_kmag_r <= k_abs[KMW-1:0];
      d_kneg_r <= k_val[KW-1];
      d_d2_r   <= c_d2_r;
      d_r1s_r  <= c_r1s_r;
      d_geo_r  <= c_geo_r;
    end
  end

  // ------------------------------------------------------- multipliers, 2 stages
  logic [D2W+RSW-1:0]   p1;
  logic [2*KMW-1:0]     kk;
  logic [KMW+N:0]       kdy_mag, kdx_mag;
  logic                 kk_vld;
  md_t                  md_r [0:1];

  assign ctl_d.adv = adv;
  assign ctl_d.vld = vld_r[3];

  cpi_mul #(.WA(D2W), .WB(RSW)) u_mul_p1 (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_d), .a(d_d2_r), .b(d_r1s_r), .p(p1), .p_vld()
  );
  cpi_mul #(.WA(KMW), .WB(KMW)) u_mul_kk (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_d), .a(d_kmag_r), .b(d_kmag_r), .p(kk), .p_vld(kk_vld)
  );
  cpi_mul #(.WA(KMW), .WB(N+1)) u_mul_kdy (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_d), .a(d_kmag_r), .b(d_geo_r.dymag), .p(kdy_mag),
    .p_vld()
  );
  cpi_mul #(.WA(KMW), .WB(N+1)) u_mul_kdx (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_d), .a(d_kmag_r), .b(d_geo_r.dxmag), .p(kdx_mag),
    .p_vld()
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      md_r[0].kneg <= d_kneg_r;
      md_r[0].d2   <= d_d2_r;
      md_r[0].geo  <= d_geo_r;
      md_r[1]      <= md_r[0];
    end
  end

  // ---------------------------------------------------------------- stage E
  // Discriminant D = 4*d2*r1^2 - K^2 and status; also feeds root stage 0
  logic signed [DSW-1:0] disc;
  logic signed [NW-1:0]  kdy_s, kdx_s;
  status_t               stat_e;

  logic [DQ-1:0]   sq_d_r    [0:SB];
  logic [SB+1:0]   sq_rem_r  [0:SB];
  logic [SB-1:0]   sq_root_r [0:SB];
  sq_t             sq_sd_r   [0:SB];

  always_comb begin
    disc  = $signed(DSW'({p1, 2'b00})) - $signed(DSW'(kk));
    kdy_s = (md_r[1].kneg ^ md_r[1].geo.dyneg) ? -$signed(NW'(kdy_mag))
                                                :  $signed(NW'(kdy_mag));
    kdx_s = (md_r[1].kneg ^ md_r[1].geo.dxneg) ? -$signed(NW'(kdx_mag))
                                                :  $signed(NW'(kdx_mag));
    if (md_r[1].geo.dxz) begin
      stat_e = ST_SAME_X;
    end else if (disc[DSW-1]) begin
      stat_e = ST_NO_MEET;
    end else begin
      stat_e = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_d_r[0]          <= disc[DQ-1:0];
      sq_rem_r[0]        <= '0;
      sq_root_r[0]       <= '0;
      sq_sd_r[0].kdy     <= kdy_s;
      sq_sd_r[0].kdx     <= kdx_s;
      sq_sd_r[0].d2      <= md_r[1].d2;
      sq_sd_r[0].xsneg   <= md_r[1].geo.dxneg ^ md_r[1].geo.dyneg;
      sq_sd_r[0].dxmag   <= md_r[1].geo.dxmag;
      sq_sd_r[0].dymag   <= md_r[1].geo.dymag;
      sq_sd_r[0].x1      <= md_r[1].geo.x1;
      sq_sd_r[0].y1      <= md_r[1].geo.y1;
      sq_sd_r[0].stat    <= stat_e;
    end
  end

  // ------------------------------------------------ floor square root, SB stages
  // Digit-by-digit: bring down two bits of D, try (4*root + 1), keep one root bit
  for (genvar j = 1; j <= SB; j++) begin : g_sq
    logic [SB+3:0] t;
    logic [SB+4:0] diff;
    logic          ge;

    always_comb begin
      t    = {sq_rem_r[j-1], sq_d_r[j-1][DQ-1:DQ-2]};
      diff = {1'b0, t} - {3'b000, sq_root_r[j-1], 2'b01};
      ge   = !diff[SB+4];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[j]  <= ge ? diff[SB+1:0] : t[SB+1:0];
        sq_root_r[j] <= {sq_root_r[j-1][SB-2:0], ge};
        sq_d_r[j]    <= {sq_d_r[j-1][DQ-3:0], 2'b00};
        sq_sd_r[j]   <= sq_sd_r[j-1];
      end
    end
  end

  // ------------------------------------------------ root products, 2 stages
  logic [SB+N:0] sdx, sdy;
  logic          sdx_vld;
  sq_t           f_r [0:1];

  assign ctl_sq.adv = adv;
  assign ctl_sq.vld = vld_r[6+SB];

  cpi_mul #(.WA(SB), .WB(N+1)) u_mul_sdx (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_sq), .a(sq_root_r[SB]), .b(sq_sd_r[SB].dxmag),
    .p(sdx), .p_vld(sdx_vld)
  );
  cpi_mul #(.WA(SB), .WB(N+1)) u_mul_sdy (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_sq), .a(sq_root_r[SB]), .b(sq_sd_r[SB].dymag),
    .p(sdy), .p_vld()
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[0] <= sq_sd_r[SB];
      f_r[1] <= f_r[0];
    end
  end

  // ---------------------------------------------------------------- stage G
  // Numerators of both points; plus root gives the larger y
  logic signed [NW-1:0] sdx_s, sdy_s;
  logic signed [NW-1:0] g_nyp_r, g_nym_r, g_nxp_r, g_nxm_r;
  logic [DNW-1:0]       g_den_r;
  ht_t                  h_r [0:QB+1];

  assign sdx_s = $signed(NW'(sdx));
  assign sdy_s = $signed(NW'(sdy));

  always_ff @(posedge clk) begin
    if (adv) begin
      g_nyp_r    <= f_r[1].kdy + sdx_s;
      g_nym_r    <= f_r[1].kdy - sdx_s;
      g_nxp_r    <= f_r[1].xsneg ? f_r[1].kdx + sdy_s : f_r[1].kdx - sdy_s;
      g_nxm_r    <= f_r[1].xsneg ? f_r[1].kdx - sdy_s : f_r[1].kdx + sdy_s;
      g_den_r    <= {f_r[1].d2, 1'b0};
      h_r[0].x1   <= f_r[1].x1;
      h_r[0].y1   <= f_r[1].y1;
      h_r[0].stat <= f_r[1].stat;
    end
  end

  // ------------------------------------------------ dividers, QB+1 stages
  pipe_ctl_t         ctl_g;
  logic signed [QB:0] q_xp, q_yp, q_xm, q_ym;
  logic               div_vld;

  assign ctl_g.adv = adv;
  assign ctl_g.vld = vld_r[9+SB];

  cpi_div #(.NW(NW), .DNW(DNW), .QB(QB)) u_div_xp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_g), .num(g_nxp_r), .den(g_den_r), .quo(q_xp),
    .quo_vld(div_vld)
  );
  cpi_div #(.NW(NW), .DNW(DNW), .QB(QB)) u_div_yp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_g), .num(g_nyp_r), .den(g_den_r), .quo(q_yp),
    .quo_vld()
  );
  cpi_div #(.NW(NW), .DNW(DNW), .QB(QB)) u_div_xm (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_g), .num(g_nxm_r), .den(g_den_r), .quo(q_xm),
    .quo_vld()
  );
  cpi_div #(.NW(NW), .DNW(DNW), .QB(QB)) u_div_ym (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_g), .num(g_nym_r), .den(g_den_r), .quo(q_ym),
    .quo_vld()
  );

  for (genvar h = 1; h <= QB+1; h++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        h_r[h] <= h_r[h-1];
      end
    end
  end

  // ------------------------------------------------------- output register
  // Add tower 1 back; zero the points unless the status is ok
  logic signed [OW-1:0] o_fx_r, o_fy_r, o_sx_r, o_sy_r;
  status_t              o_stat_r;
  logic                 ok_h;

  assign ok_h = (h_r[QB+1].stat == ST_OK);

  always_ff @(posedge clk) begin
    if (adv) begin
      o_fx_r   <= ok_h ? OW'(h_r[QB+1].x1) + OW'(q_xp) : '0;
      o_fy_r   <= ok_h ? OW'(h_r[QB+1].y1) + OW'(q_yp) : '0;
      o_sx_r   <= ok_h ? OW'(h_r[QB+1].x1) + OW'(q_xm) : '0;
      o_sy_r   <= ok_h ? OW'(h_r[QB+1].y1) + OW'(q_ym) : '0;
      o_stat_r <= h_r[QB+1].stat;
    end
  end

  assign out_tdata  = OUT_DW'({o_sy_r, o_sx_r, o_fy_r, o_fx_r});
  assign out_tuser  = o_stat_r;
  assign out_tvalid = vld_r[LAT-1];

  // ------------------------------------------------------------- assertions
  a_mul_align: assert property (@(posedge clk) disable iff (!rst_n)
    kk_vld == vld_r[5])
    else $error("K^2 product out of step with pipeline valid");

  a_root_mul_align: assert property (@(posedge clk) disable iff (!rst_n)
    sdx_vld == vld_r[8+SB])
    else $error("root product out of step with pipeline valid");

  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld == vld_r[10+SB+QB])
    else $error("divider out of step with pipeline valid");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_stat_r != ST_OK) |->
      (o_fx_r == '0 && o_fy_r == '0 && o_sx_r == '0 && o_sy_r == '0))
    else $error("points not zero for failed fix");

  a_plus_root_higher: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_stat_r == ST_OK) |-> (o_fy_r >= o_sy_r))
    else $error("plus-root point below minus-root point");

endmodule

### sim/circle_pair_intersection_top_tb.sv
`timescale 1ns / 100ps

module circle_pair_intersection_top_tb;
  import cpi_pkg::*;

  localparam int CB = 24;
  localparam int OB = CB + 2;
  localparam int IN_W = ((6*CB-2+7)/8)*8;
  localparam int OUT_W = ((4*OB+7)/8)*8;
  localparam int LATENCY = 12 + (2*CB+1) + (CB-1);

  typedef struct {
    logic signed [CB-1:0] x1, y1, x2, y2;
    logic [CB-2:0] r1, r2;
  } tower_pair_t;

  typedef struct {
    logic [OB-1:0] fx, fy, sx, sy;
    status_t st;
  } fix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;

  tower_pair_t pending_pairs[$];
  fix_t expected_fixes[$];
  tower_pair_t pair_on_bus;
  bit in_took, out_took;
  int errors = 0, fixes_seen = 0, pairs_sent = 0;
  int n_ok = 0, n_no_meet = 0, n_same_x = 0;
  int send_gap = 0, recv_wait = 0, long_hold = 0;
  bit send_bursty = 1'b1, recv_bursty = 1'b1, long_hold_done = 1'b0;

  circle_pair_intersection_top #(.COORD_BITS(CB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready)
  );

  always #5 clk = ~clk;

  function automatic logic signed [159:0] floor_sqrt(logic signed [159:0] n);
    logic signed [159:0] root, trial;
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (160'sd1 <<< b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Solve the two range circles exactly in wide integers; only the root is
  // floored and the four quotients truncated.
  function automatic fix_t solve_pair(tower_pair_t p);
    logic signed [159:0] x1, y1, dx, dy, r1, r2, d2, r1s, k, disc, root, den;
    logic signed [159:0] adx, sdx, yn, xn, qy, qx;
    fix_t f;
    x1 = 160'(p.x1); y1 = 160'(p.y1); r1 = 160'(p.r1); r2 = 160'(p.r2);
    dx = p.x2 - x1;
    dy = p.y2 - y1;
    f.fx = '0; f.fy = '0; f.sx = '0; f.sy = '0; f.st = ST_OK;
    if (dx == 0) begin
      f.st = ST_SAME_X;
      return f;
    end
    d2 = dx*dx + dy*dy;
    r1s = r1*r1;
    k = r1s - r2*r2 + d2;
    disc = 4*d2*r1s - k*k;
    if (disc < 0) begin
      f.st = ST_NO_MEET;
      return f;
    end
    root = floor_sqrt(disc);
    den = 2*d2;
    adx = (dx < 0) ? -dx : dx;
    sdx = (dx < 0) ? -1 : 1;
    for (int s = 1; s >= -1; s -= 2) begin
      yn = k*dy + s*adx*root;
      xn = k*dx - s*sdx*dy*root;
      qy = y1 + yn / den;
      qx = x1 + xn / den;
      if (s == 1) begin
        f.fx = qx[OB-1:0]; f.fy = qy[OB-1:0];
      end else begin
        f.sx = qx[OB-1:0]; f.sy = qy[OB-1:0];
      end
    end
    return f;
  endfunction

  task automatic queue_pair(int x1, int y1, int r1, int x2, int y2, int r2);
    tower_pair_t p;
    p.x1 = CB'(x1); p.y1 = CB'(y1); p.r1 = (CB-1)'(r1);
    p.x2 = CB'(x2); p.y2 = CB'(y2); p.r2 = (CB-1)'(r2);
    pending_pairs.push_back(p);
  endtask

  function automatic int rand_span(int m);
    return $signed($urandom_range(0, 2*m - 1)) - m;
  endfunction

  task automatic check_field(string name, logic [OB-1:0] exp_v, logic [OB-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Sample both channels at the rising edge; predict on each input transfer.
  always @(posedge clk) begin
    fix_t exp_f;
    in_took = in_tvalid && in_tready;
    out_took = out_tvalid && out_tready;
    if (rst_n && in_took) begin
      expected_fixes.push_back(solve_pair(pair_on_bus));
      pairs_sent++;
    end
    if (rst_n && out_took) begin
      fixes_seen++;
      if (expected_fixes.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_f = expected_fixes.pop_front();
        check_field("first_x", exp_f.fx, out_tdata[OB-1:0]);
        check_field("first_y", exp_f.fy, out_tdata[2*OB-1:OB]);
        check_field("second_x", exp_f.sx, out_tdata[3*OB-1:2*OB]);
        check_field("second_y", exp_f.sy, out_tdata[4*OB-1:3*OB]);
        check_field("status", OB'(exp_f.st), OB'(out_tuser));
        case (exp_f.st)
          ST_OK: n_ok++;
          ST_NO_MEET: n_no_meet++;
          default: n_same_x++;
        endcase
      end
    end
  end

  // Driver: hold an offered pair until its transfer, then idle a drawn gap.
  always @(negedge clk) begin
    tower_pair_t p;
    if (rst_n && !(in_tvalid && !in_took)) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_pairs.size() > 0) begin
        p = pending_pairs.pop_front();
        pair_on_bus = p;
        in_tdata <= {2'b00, p.r2, p.y2, p.x2, p.r1, p.y1, p.x1};
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 99) == 0) send_bursty = !send_bursty;
        send_gap = send_bursty ? 0 : $urandom_range(0, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall a drawn count per result; once, hold off long enough
  // to fill the pipeline and back-pressure the input.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && fixes_seen == 300) begin
        long_hold_done = 1'b1;
        long_hold = 4 * LATENCY;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_tready <= 1'b0;
      end else if (out_took || recv_wait > 0) begin
        if (out_took) begin
          if ($urandom_range(0, 99) == 0) recv_bursty = !recv_bursty;
          recv_wait = recv_bursty ? 0 : $urandom_range(0, 15);
        end
        if (recv_wait > 0) begin
          recv_wait--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int sh, m, px, py, x1, y1, x2, y2, kind;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: shared x, coincident towers, zero ranges, apart, nested,
    // both tangencies, an ordinary crossing, and the coordinate extremes.
    queue_pair(0, 0, 100, 0, 500, 100);
    queue_pair(5, 5, 10, 5, 5, 10);
    queue_pair(0, 0, 0, 256, 0, 0);
    queue_pair(0, 0, 256, 10000, 0, 256);
    queue_pair(0, 0, 5000, 100, 0, 10);
    queue_pair(0, 0, 100, 200, 0, 100);
    queue_pair(0, 0, 200, 100, 0, 100);
    queue_pair(0, 0, 500, 600, 100, 400);
    queue_pair(600, 100, 400, 0, 0, 500);
    queue_pair(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607);
    queue_pair(8388607, -8388608, 8388607, -8388608, 8388607, 8388607);
    queue_pair(-8388608, 0, 0, 8388607, 0, 8388607);
    queue_pair(-8388608, 8388607, 8388607, -8388607, -8388608, 8388607);
    queue_pair(-4000000, 0, 4194303, 4000000, 0, 4194303);
    queue_pair(-8388608, -8388608, 0, -8388608, 8388607, 0);

    // Pause the sender until every directed result has returned.
    wait (pending_pairs.size() == 0 && !in_tvalid && expected_fixes.size() == 0);

    for (int i = 0; i < 1950; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // Circles built through a common point so that most of them meet.
        sh = $urandom_range(2, 21);
        m = 1 << sh;
        x1 = rand_span(m); y1 = rand_span(m);
        x2 = rand_span(m); y2 = rand_span(m);
        px = rand_span(m); py = rand_span(m);
        queue_pair(x1, y1, int'(floor_sqrt(160'(longint'(px-x1)*(px-x1)
                                   + longint'(py-y1)*(py-y1))) + $urandom_range(0, 1)),
                   x2, y2, int'(floor_sqrt(160'(longint'(px-x2)*(px-x2)
                                   + longint'(py-y2)*(py-y2)))));
      end else if (kind < 94) begin
        queue_pair(rand_span(1 << 23), rand_span(1 << 23), $urandom_range(0, 8388607),
                   rand_span(1 << 23), rand_span(1 << 23), $urandom_range(0, 8388607));
      end else begin
        x1 = rand_span(1 << 23);
        queue_pair(x1, rand_span(1 << 23), $urandom_range(0, 8388607),
                   x1, rand_span(1 << 23), $urandom_range(0, 8388607));
      end
    end

    wait (pending_pairs.size() == 0 && !in_tvalid && expected_fixes.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_fixes.size() != 0) begin
      $error("%0d results never arrived", expected_fixes.size());
      errors++;
    end
    $display("Sent %0d tower pairs, checked %0d results: %0d crossing, %0d apart,",
             pairs_sent, fixes_seen, n_ok, n_no_meet);
    $display("%0d with shared x; one long receiver hold-off and one sender pause.",
             n_same_x);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
